[sv/ssmr_pkg.sv]
`default_nettype none

package ssmr_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_STRAIGHT_POS    = 3'd0;
    localparam logic [2:0] CFG_TURNOUT_POS     = 3'd1;
    localparam logic [2:0] CFG_STEP_SIZE       = 3'd2;
    localparam logic [2:0] CFG_POWER_SLOT      = 3'd3;
    localparam logic [2:0] CFG_FEEDBACK_SLOT_A = 3'd4;
    localparam logic [2:0] CFG_FEEDBACK_SLOT_B = 3'd5;

    localparam logic [15:0] POS_RESET  = 16'd1500;
    localparam logic [9:0]  STEP_RESET = 10'd2;

    // Job queue between the front and the back part
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_SET     = 2'd1,
        MODE_TOGGLE  = 2'd2,
        MODE_RESTORE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        MS_START = 2'd0,
        MS_MOVE  = 2'd1,
        MS_STOP  = 2'd2
    } t_motion;

    typedef enum logic [1:0] {
        RES_PULSE    = 2'd0,
        RES_POWER    = 2'd1,
        RES_FEEDBACK = 2'd2,
        RES_ATTACH   = 2'd3
    } t_res_kind;

    typedef enum logic [1:0] {
        JOB_SET    = 2'd0,
        JOB_STOP   = 2'd1,
        JOB_PULSE  = 2'd2,
        JOB_ATTACH = 2'd3
    } t_job_kind;

    typedef struct packed {
        logic [15:0] straight_pos;
        logic [15:0] turnout_pos;
        logic [9:0]  step_size;
        logic [11:0] power_slot;
        logic [11:0] feedback_slot_a;
        logic [11:0] feedback_slot_b;
    } t_cfg;

    typedef struct packed {
        t_job_kind   kind;
        logic        rep_a;
        logic        rep_b;
        logic [15:0] pulse_width;
    } t_job;

endpackage

`default_nettype wire

[sv/ssmr_front.sv]
`default_nettype none

module ssmr_front
    import ssmr_pkg::*;
#(
    parameter int TICK_DIVIDE = 250
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_valid,
    input  wire t_mode i_mode,
    input  wire logic  i_dir,
    input  wire logic  i_room,
    output logic       o_push,
    output t_job       o_job
);

    localparam int CNT_W = $clog2(TICK_DIVIDE + 2);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(TICK_DIVIDE + 1);
    localparam logic [CNT_W-1:0] CNT_DIV = CNT_W'(TICK_DIVIDE);

    logic [15:0]        r_cur, n_cur;
    logic [15:0]        r_tgt, n_tgt;
    logic signed [11:0] r_step, n_step;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    t_motion            r_state, n_state;
    logic               r_dir, n_dir;

    logic               accept;
    logic               dir_sel;
    logic [15:0]        end_pos;
    logic [16:0]        diff;
    logic [15:0]        span;
    logic [11:0]        mag;
    logic               near;
    logic [CNT_W-1:0]   cnt_inc;
    logic               fire;
    logic signed [17:0] p_sum;
    logic [15:0]        p_clamp;
    logic               moving;
    logic [11:0]        step_pos;

    assign accept   = i_valid & i_room;
    assign dir_sel  = (i_mode == MODE_TOGGLE) ? ~r_dir : i_dir;
    assign end_pos  = dir_sel ? i_cfg.turnout_pos : i_cfg.straight_pos;
    assign diff     = {1'b0, r_cur} - {1'b0, r_tgt};
    assign span     = diff[16] ? 16'(-diff) : diff[15:0];
    assign mag      = r_step[11] ? 12'(-r_step) : 12'(r_step);
    assign near     = span < {4'b0, mag};
    assign cnt_inc  = (r_cnt == CNT_CAP) ? r_cnt : r_cnt + 1'b1;
    assign fire     = cnt_inc > CNT_DIV;
    assign p_sum    = $signed({2'b00, r_cur}) + $signed({{6{r_step[11]}}, r_step});
    assign moving   = (r_state == MS_MOVE);
    assign step_pos = {2'b00, i_cfg.step_size};

    // Position saturates to the 16-bit range.
    always_comb begin
        if (p_sum[17]) begin
            p_clamp = '0;
        end else if (p_sum[16]) begin
            p_clamp = '1;
        end else begin
            p_clamp = p_sum[15:0];
        end
    end

    always_comb begin
        n_state = r_state;
        if (accept) begin
            case (i_mode)
                MODE_TICK: begin
                    if (r_state != MS_STOP) begin
                        if (near) begin
                            n_state = MS_STOP;
                        end else if (fire && !moving) begin
                            n_state = MS_MOVE;
                        end
                    end
                end
                MODE_SET, MODE_TOGGLE: begin
                    n_state = MS_MOVE;
                end
                MODE_RESTORE: begin
                    n_state = MS_START;
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_comb begin
        n_cur  = r_cur;
        n_tgt  = r_tgt;
        n_step = r_step;
        n_cnt  = r_cnt;
        n_dir  = r_dir;
        o_push = 1'b0;
        o_job  = '{kind: JOB_PULSE, rep_a: 1'b0, rep_b: 1'b0, pulse_width: 16'd0};
        if (accept) begin
            case (i_mode)
                MODE_TICK: begin
                    if (r_state != MS_STOP) begin
                        if (near) begin
                            // Reports follow the direction once stopped.
                            o_push      = 1'b1;
                            o_job.kind  = JOB_STOP;
                            o_job.rep_a = ~r_dir;
                            o_job.rep_b = r_dir;
                        end else begin
                            n_cnt = cnt_inc;
                            if (fire) begin
                                o_push = 1'b1;
                                if (moving) begin
                                    n_cur             = p_clamp;
                                    n_cnt             = '0;
                                    o_job.kind        = JOB_PULSE;
                                    o_job.pulse_width = p_clamp;
                                    if (r_step == 12'sd0 && r_tgt == p_clamp) begin
                                        n_step = 12'sd1;
                                    end
                                end else begin
                                    o_job.kind = JOB_ATTACH;
                                end
                            end
                        end
                    end
                end
                MODE_SET, MODE_TOGGLE: begin
                    n_tgt  = end_pos;
                    n_step = (end_pos < r_cur) ? $signed(-step_pos) : $signed(step_pos);
                    n_dir  = dir_sel;
                    // Reports carry the direction and motion from before the command.
                    o_push      = 1'b1;
                    o_job.kind  = JOB_SET;
                    o_job.rep_a = ~moving & ~r_dir;
                    o_job.rep_b = ~moving & r_dir;
                end
                MODE_RESTORE: begin
                    n_dir  = i_dir;
                    n_tgt  = end_pos;
                    n_cur  = end_pos;
                    n_step = 12'sd0;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= POS_RESET;
            r_tgt   <= POS_RESET;
            r_step  <= 12'sd0;
            r_cnt   <= '0;
            r_state <= MS_START;
            r_dir   <= 1'b0;
        end else begin
            r_cur   <= n_cur;
            r_tgt   <= n_tgt;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_state <= n_state;
            r_dir   <= n_dir;
        end
    end

endmodule

`default_nettype wire

[sv/ssmr_queue.sv]
`default_nettype none

module ssmr_queue
    import ssmr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_room,
    output logic      o_avail,
    output t_job      o_head
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_room  = (r_count != QCNT_W'(QDEPTH));
    assign o_avail = (r_count != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_avail)
        else $error("job popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue fill count out of range");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not raise the fill count");
`endif

endmodule

`default_nettype wire

[sv/ssmr_back.sv]
`default_nettype none

module ssmr_back
    import ssmr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_avail,
    input  wire t_job  i_head,
    output logic       o_pop,
    input  wire logic  i_ready,
    output logic       o_valid,
    output t_res_kind  o_kind,
    output logic [11:0] o_slot_number,
    output logic       o_slot_value,
    output logic [15:0] o_pulse_width,
    output logic       o_last
);

    logic        r_valid;
    t_res_kind   r_kind, n_kind;
    logic [11:0] r_slot, n_slot;
    logic        r_value, n_value;
    logic [15:0] r_pw, n_pw;
    logic        r_last, n_last;
    logic [1:0]  r_idx;

    logic        load;

    assign load  = i_avail & (~r_valid | i_ready);
    assign o_pop = load & n_last;

    // Word of the job at the head of the queue, picked by the word index.
    always_comb begin
        n_kind  = RES_PULSE;
        n_slot  = '0;
        n_value = 1'b0;
        n_pw    = '0;
        n_last  = 1'b1;
        case (i_head.kind)
            JOB_SET, JOB_STOP: begin
                n_last = (r_idx == 2'd2);
                case (r_idx)
                    2'd0: begin
                        n_kind  = RES_POWER;
                        n_slot  = i_cfg.power_slot;
                        n_value = (i_head.kind == JOB_SET);
                    end
                    2'd1: begin
                        n_kind  = RES_FEEDBACK;
                        n_slot  = i_cfg.feedback_slot_a;
                        n_value = i_head.rep_a;
                    end
                    default: begin
                        n_kind  = RES_FEEDBACK;
                        n_slot  = i_cfg.feedback_slot_b;
                        n_value = i_head.rep_b;
                    end
                endcase
            end
            JOB_PULSE: begin
                n_kind = RES_PULSE;
                n_pw   = i_head.pulse_width;
            end
            JOB_ATTACH: begin
                n_kind = RES_ATTACH;
            end
            default: begin
                n_kind = RES_PULSE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= n_last ? 2'd0 : r_idx + 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= n_kind;
            r_slot  <= n_slot;
            r_value <= n_value;
            r_pw    <= n_pw;
            r_last  <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_slot_number = r_slot;
    assign o_slot_value  = r_value;
    assign o_pulse_width = r_pw;
    assign o_last        = r_last;

endmodule

`default_nettype wire

[sv/servo_slow_motion_ramp.sv]
`default_nettype none

// Channel   Direction  tuser             tdata                                       tlast
// s_axis    in         [1:0] mode        [0] direction                               -
// m_axis    out        [1:0] kind        [11:0] slot_number [12] slot_value          last
//                                        [28:13] pulse_width
// cfg       in         -                 i_cfg_index selects, i_cfg_data written     -
//
// The front part takes one input word per cycle while the four-entry job queue has room.
// The back part sends one result word per cycle while the output is ready, from the job at
// the queue head; a set, toggle or stop gives three words and a pulse or attach gives one.
// A tick that causes no result never enters the queue.
// Reset is synchronous and active low; positions come up at 1500 with the motion in start.
// A stalled output holds its word while the queue keeps filling from the input side.

module servo_slow_motion_ramp
    import ssmr_pkg::*;
#(
    parameter int TICK_DIVIDE = 250
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [0] direction
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [11:0] slot_number, [12] slot_value,
                                             // [28:13] pulse_width
    output logic [1:0]       m_axis_tuser,   // [1:0] kind
    output logic             m_axis_tlast,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic        push;
    t_job        job;
    logic        room;
    logic        avail;
    logic        pop;
    t_job        head;
    t_res_kind   kind;
    logic [11:0] slot_number;
    logic        slot_value;
    logic [15:0] pulse_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.straight_pos    <= POS_RESET;
            r_cfg.turnout_pos     <= POS_RESET;
            r_cfg.step_size       <= STEP_RESET;
            r_cfg.power_slot      <= '0;
            r_cfg.feedback_slot_a <= '0;
            r_cfg.feedback_slot_b <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STRAIGHT_POS:    r_cfg.straight_pos    <= i_cfg_data;
                CFG_TURNOUT_POS:     r_cfg.turnout_pos     <= i_cfg_data;
                CFG_STEP_SIZE:       r_cfg.step_size       <= i_cfg_data[9:0];
                CFG_POWER_SLOT:      r_cfg.power_slot      <= i_cfg_data[11:0];
                CFG_FEEDBACK_SLOT_A: r_cfg.feedback_slot_a <= i_cfg_data[11:0];
                CFG_FEEDBACK_SLOT_B: r_cfg.feedback_slot_b <= i_cfg_data[11:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    assign s_axis_tready = room;

    ssmr_front #(
        .TICK_DIVIDE (TICK_DIVIDE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s_axis_tvalid),
        .i_mode  (t_mode'(s_axis_tuser)),
        .i_dir   (s_axis_tdata[0]),
        .i_room  (room),
        .o_push  (push),
        .o_job   (job)
    );

    ssmr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_room  (room),
        .o_avail (avail),
        .o_head  (head)
    );

    ssmr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_avail       (avail),
        .i_head        (head),
        .o_pop         (pop),
        .i_ready       (m_axis_tready),
        .o_valid       (m_axis_tvalid),
        .o_kind        (kind),
        .o_slot_number (slot_number),
        .o_slot_value  (slot_value),
        .o_pulse_width (pulse_width),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {3'b000, pulse_width, slot_value, slot_number};

endmodule

`default_nettype wire
